[rtl/core/acir_pkg.sv]
// Shared types, constants and frame helpers for the AC IR frame pulse encoder.
// No dependencies.
package acir_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Register indexes.
    localparam int          CFG_IDX_W       = 3;
    localparam logic [2:0]  CFG_HEADER_MARK = 3'd0;
    localparam logic [2:0]  CFG_HEADER_GAP  = 3'd1;
    localparam logic [2:0]  CFG_BIT_MARK    = 3'd2;
    localparam logic [2:0]  CFG_ONE_SPACE   = 3'd3;
    localparam logic [2:0]  CFG_ZERO_SPACE  = 3'd4;
    localparam logic [2:0]  CFG_TRAILER_GAP = 3'd5;

    // Register reset values (microseconds).
    localparam logic [15:0] RST_HEADER_MARK = 16'd3000;
    localparam logic [15:0] RST_HEADER_GAP  = 16'd4300;
    localparam logic [15:0] RST_BIT_MARK    = 16'd520;
    localparam logic [15:0] RST_ONE_SPACE   = 16'd1650;
    localparam logic [15:0] RST_ZERO_SPACE  = 16'd650;
    localparam logic [15:0] RST_TRAILER_GAP = 16'd30000;

    // Frame constants.
    localparam logic [7:0] FRAME_PREFIX = 8'hA5;
    localparam logic [7:0] POWER_CMD    = 8'h01;
    localparam logic [7:0] SWING_BASE   = 8'h20;
    localparam logic [7:0] OFF_TIMER    = 8'd12 & 8'h1F;
    localparam logic [7:0] TEMP_MIN     = 8'd16;
    localparam logic [7:0] TEMP_MAX     = 8'd30;
    localparam logic [2:0] MODE_FAN     = 3'd4;
    localparam logic [2:0] MODE_AUTO    = 3'd0;

    // Duration positions.
    localparam logic [7:0] POS_HEADER_GAP   = 8'd3;
    localparam logic [7:0] POS_BIT_BASE     = 8'd4;
    localparam logic [7:0] POS_TRAILER_MARK = 8'd148;
    localparam logic [7:0] POS_LAST         = 8'd149;

    typedef struct packed {
        logic [15:0] header_mark;
        logic [15:0] header_gap;
        logic [15:0] bit_mark;
        logic [15:0] one_space;
        logic [15:0] zero_space;
        logic [15:0] trailer_gap;
    } cfg_t;

    typedef struct packed {
        logic [15:0] duration;
        logic        is_mark;
        logic        last;
    } result_t;

    function automatic logic [1:0] wire_fan(input logic [1:0] fan);
        logic [1:0] w;
        case (fan)
            2'd0:    w = 2'd0;
            2'd1:    w = 2'd3;
            2'd2:    w = 2'd2;
            default: w = 2'd1;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] wire_mode(input logic [2:0] mode);
        return (mode <= MODE_FAN) ? mode : MODE_AUTO;
    endfunction

endpackage

[rtl/core/ac_ir_frame_pulse_encoder.sv]
// Top level of the AC IR frame pulse encoder.
// Depends on acir_pkg, acir_cfg_regs, acir_seq and acir_out_buf.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | s_valid / s_ready  | s_op s_temperature s_op_mode s_fan_speed s_swing_on
//  result   | m_valid / m_ready  | m_duration m_is_mark m_last
//  config   | cfg_wr_en          | cfg_index cfg_wdata
//
// One word per cycle while s_ready is high; each result word is registered before it appears on m_*.
// The position counter and frame store update in the accept cycle, so words
// can follow back to back. A skid word keeps s_ready high for one extra word
// while m_ready is low; s_ready drops only when both output slots are full.
// Synchronous active-low reset clears the position counter and loads register defaults.
module ac_ir_frame_pulse_encoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [7:0]                     s_temperature,
    input  logic [2:0]                     s_op_mode,
    input  logic [1:0]                     s_fan_speed,
    input  logic                           s_swing_on,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_duration,
    output logic                           m_is_mark,
    output logic                           m_last,
    input  logic                           cfg_wr_en,
    input  logic [acir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata
);

    acir_pkg::cfg_t    cfg;
    acir_pkg::result_t res;
    acir_pkg::result_t m_res;
    logic              res_valid;

    acir_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acir_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_valid && s_ready),
        .op          (s_op),
        .temperature (s_temperature),
        .op_mode     (s_op_mode),
        .fan_speed   (s_fan_speed),
        .swing_on    (s_swing_on),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    acir_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_res   (m_res),
        .out_ready (m_ready)
    );

    assign m_duration = m_res.duration;
    assign m_is_mark  = m_res.is_mark;
    assign m_last     = m_res.last;

endmodule

[rtl/core/acir_cfg_regs.sv]
// Timing register file for the AC IR frame pulse encoder.
// Depends on acir_pkg.
module acir_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [acir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata,
    output acir_pkg::cfg_t                 cfg
);

    acir_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_mark <= acir_pkg::RST_HEADER_MARK;
            cfg_reg.header_gap  <= acir_pkg::RST_HEADER_GAP;
            cfg_reg.bit_mark    <= acir_pkg::RST_BIT_MARK;
            cfg_reg.one_space   <= acir_pkg::RST_ONE_SPACE;
            cfg_reg.zero_space  <= acir_pkg::RST_ZERO_SPACE;
            cfg_reg.trailer_gap <= acir_pkg::RST_TRAILER_GAP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                acir_pkg::CFG_HEADER_MARK: cfg_reg.header_mark <= cfg_wdata;
                acir_pkg::CFG_HEADER_GAP:  cfg_reg.header_gap  <= cfg_wdata;
                acir_pkg::CFG_BIT_MARK:    cfg_reg.bit_mark    <= cfg_wdata;
                acir_pkg::CFG_ONE_SPACE:   cfg_reg.one_space   <= cfg_wdata;
                acir_pkg::CFG_ZERO_SPACE:  cfg_reg.zero_space  <= cfg_wdata;
                acir_pkg::CFG_TRAILER_GAP: cfg_reg.trailer_gap <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/acir_frame_build.sv]
// Builds the 9-byte frame, byte 0 in the low bits, from one start word.
// Depends on acir_pkg.
module acir_frame_build (
    input  logic [7:0]                      temperature,
    input  logic [2:0]                      op_mode,
    input  logic [1:0]                      fan_speed,
    input  logic                            swing_on,
    output logic [acir_pkg::FRAME_BITS-1:0] frame
);

    logic [7:0] temp_clamped;
    logic [7:0] temp_ofs;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] checksum;

    always_comb begin
        if (temperature < acir_pkg::TEMP_MIN) begin
            temp_clamped = acir_pkg::TEMP_MIN;
        end else if (temperature > acir_pkg::TEMP_MAX) begin
            temp_clamped = acir_pkg::TEMP_MAX;
        end else begin
            temp_clamped = temperature;
        end
        temp_ofs = temp_clamped - acir_pkg::TEMP_MIN;
        byte1    = acir_pkg::POWER_CMD | {temp_ofs[3:0], 4'b0000};
        byte2    = acir_pkg::SWING_BASE | {{2{swing_on}}, 6'b000000};
        byte5    = {acir_pkg::wire_fan(fan_speed), 6'b000000};
        byte6    = {acir_pkg::wire_mode(op_mode), 5'b00000};
        checksum = acir_pkg::FRAME_PREFIX + byte1 + byte2 + acir_pkg::OFF_TIMER
                   + byte5 + byte6;
        frame    = {checksum, 8'h00, byte6, byte5, acir_pkg::OFF_TIMER, 8'h00,
                    byte2, byte1, acir_pkg::FRAME_PREFIX};
    end

endmodule

[rtl/core/acir_seq.sv]
// Frame store, position counter and duration select for the AC IR encoder.
// Depends on acir_pkg and acir_frame_build.
module acir_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  op,
    input  logic [7:0]            temperature,
    input  logic [2:0]            op_mode,
    input  logic [1:0]            fan_speed,
    input  logic                  swing_on,
    input  acir_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output acir_pkg::result_t     res
);

    logic [acir_pkg::FRAME_BITS-1:0] built_frame;
    logic [acir_pkg::FRAME_BITS-1:0] frame_reg;
    logic [7:0]                      position_reg;
    logic [7:0]                      position_next;
    logic                            active_reg;
    logic                            active_next;
    logic                            start;
    logic [7:0]                      pos;
    logic [7:0]                      bit_ofs;
    logic [acir_pkg::BIT_IDX_W-1:0]  bit_idx;

    acir_frame_build u_build (
        .temperature (temperature),
        .op_mode     (op_mode),
        .fan_speed   (fan_speed),
        .swing_on    (swing_on),
        .frame       (built_frame)
    );

    always_comb begin
        start     = accept && (op == acir_pkg::OP_START);
        res_valid = start || (accept && active_reg);
        pos       = start ? 8'd0 : position_reg;
        bit_ofs   = pos - acir_pkg::POS_BIT_BASE;
        bit_idx   = bit_ofs[acir_pkg::BIT_IDX_W:1];

        if (pos < acir_pkg::POS_HEADER_GAP) begin
            res.duration = cfg.header_mark;
        end else if (pos == acir_pkg::POS_HEADER_GAP) begin
            res.duration = cfg.header_gap;
        end else if (pos >= acir_pkg::POS_LAST) begin
            res.duration = cfg.trailer_gap;
        end else if (!pos[0] || pos == acir_pkg::POS_TRAILER_MARK) begin
            res.duration = cfg.bit_mark;
        end else begin
            res.duration = frame_reg[bit_idx] ? cfg.one_space : cfg.zero_space;
        end
        res.is_mark = ~pos[0];
        res.last    = (pos == acir_pkg::POS_LAST);

        position_next = position_reg;
        active_next   = active_reg;
        if (res_valid) begin
            if (pos >= acir_pkg::POS_LAST) begin
                position_next = 8'd0;
                active_next   = 1'b0;
            end else begin
                position_next = pos + 8'd1;
                active_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= 8'd0;
            active_reg   <= 1'b0;
        end else begin
            position_reg <= position_next;
            active_reg   <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            frame_reg <= built_frame;
        end
    end

endmodule

[rtl/core/acir_out_buf.sv]
// Output register with a skid word in front of the result channel.
// Depends on acir_pkg.
module acir_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  acir_pkg::result_t in_res,
    output logic              in_ready,
    output logic              out_valid,
    output acir_pkg::result_t out_res,
    input  logic              out_ready
);

    logic              out_valid_reg;
    logic              out_valid_next;
    acir_pkg::result_t out_reg;
    acir_pkg::result_t out_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    acir_pkg::result_t skid_reg;
    acir_pkg::result_t skid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (in_valid) begin
            if (!out_valid_next) begin
                out_next       = in_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = in_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

[sim/acir_frame_checker.sv]
// Checker for the AC IR frame pulse encoder: tracks timing registers and frame
// state from the input and config ports, predicts each result word and compares.
// Depends on acir_pkg.
module acir_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_op,
    input  logic [7:0]                     s_temperature,
    input  logic [2:0]                     s_op_mode,
    input  logic [1:0]                     s_fan_speed,
    input  logic                           s_swing_on,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [15:0]                    m_duration,
    input  logic                           m_is_mark,
    input  logic                           m_last,
    input  logic                           cfg_wr_en,
    input  logic [acir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    acir_pkg::cfg_t    timing;
    logic [7:0]        frame_img [acir_pkg::FRAME_BYTES];
    logic [7:0]        next_pos;
    logic              frame_open;
    acir_pkg::result_t expected_words [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void load_frame(logic [7:0] temp, logic [2:0] mode,
                                       logic [1:0] fan, logic swing);
        logic [7:0] t;
        logic [7:0] sum;
        int         i;
        t = (temp < acir_pkg::TEMP_MIN) ? acir_pkg::TEMP_MIN :
            (temp > acir_pkg::TEMP_MAX) ? acir_pkg::TEMP_MAX : temp;
        frame_img[0] = acir_pkg::FRAME_PREFIX;
        frame_img[1] = acir_pkg::POWER_CMD | ((t - acir_pkg::TEMP_MIN) << 4);
        frame_img[2] = acir_pkg::SWING_BASE | (swing ? 8'hC0 : 8'h00);
        frame_img[3] = 8'h00;
        frame_img[4] = acir_pkg::OFF_TIMER;
        // wire fan code is the two's complement of the speed: 0,3,2,1
        frame_img[5] = {2'd0 - fan, 6'd0};
        frame_img[6] = {(mode > acir_pkg::MODE_FAN) ? acir_pkg::MODE_AUTO : mode, 5'd0};
        frame_img[7] = 8'h00;
        sum = 8'h00;
        for (i = 0; i < acir_pkg::FRAME_BYTES - 1; i++)
            sum += frame_img[i];
        frame_img[acir_pkg::FRAME_BYTES-1] = sum;
    endfunction

    function automatic logic [15:0] duration_for(logic [7:0] p);
        int bit_no;
        if (p < acir_pkg::POS_HEADER_GAP)
            return timing.header_mark;
        if (p == acir_pkg::POS_HEADER_GAP)
            return timing.header_gap;
        if (p == acir_pkg::POS_TRAILER_MARK)
            return timing.bit_mark;
        if (p >= acir_pkg::POS_LAST)
            return timing.trailer_gap;
        if (!p[0])
            return timing.bit_mark;
        bit_no = int'(p - acir_pkg::POS_BIT_BASE) >> 1;
        return frame_img[bit_no / 8][bit_no % 8] ? timing.one_space : timing.zero_space;
    endfunction

    always @(posedge aclk) begin
        acir_pkg::result_t word;
        acir_pkg::result_t want;
        if (!aresetn) begin
            timing     = {acir_pkg::RST_HEADER_MARK, acir_pkg::RST_HEADER_GAP,
                          acir_pkg::RST_BIT_MARK, acir_pkg::RST_ONE_SPACE,
                          acir_pkg::RST_ZERO_SPACE, acir_pkg::RST_TRAILER_GAP};
            frame_open = 1'b0;
            next_pos   = 8'd0;
            for (int i = 0; i < acir_pkg::FRAME_BYTES; i++)
                frame_img[i] = 8'h00;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_op == acir_pkg::OP_START) begin
                    load_frame(s_temperature, s_op_mode, s_fan_speed, s_swing_on);
                    next_pos   = 8'd0;
                    frame_open = 1'b1;
                end
                if (frame_open) begin
                    word.duration = duration_for(next_pos);
                    word.is_mark  = ~next_pos[0];
                    word.last     = (next_pos == acir_pkg::POS_LAST);
                    expected_words.push_back(word);
                    if (next_pos == acir_pkg::POS_LAST) begin
                        frame_open = 1'b0;
                        next_pos   = 8'd0;
                    end else begin
                        next_pos++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with none pending", m_duration, 16'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_duration !== want.duration)
                        report_mismatch("duration", m_duration, want.duration);
                    if (m_is_mark !== want.is_mark)
                        report_mismatch("is_mark", 16'(m_is_mark), 16'(want.is_mark));
                    if (m_last !== want.last)
                        report_mismatch("last", 16'(m_last), 16'(want.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    acir_pkg::CFG_HEADER_MARK: timing.header_mark = cfg_wdata;
                    acir_pkg::CFG_HEADER_GAP:  timing.header_gap  = cfg_wdata;
                    acir_pkg::CFG_BIT_MARK:    timing.bit_mark    = cfg_wdata;
                    acir_pkg::CFG_ONE_SPACE:   timing.one_space   = cfg_wdata;
                    acir_pkg::CFG_ZERO_SPACE:  timing.zero_space  = cfg_wdata;
                    acir_pkg::CFG_TRAILER_GAP: timing.trailer_gap = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending <= expected_words.size();
    end

endmodule

[sim/tb_ac_ir_frame_pulse_encoder.sv]
// Testbench top for the AC IR frame pulse encoder: clock, reset, directed and
// random frame stimulus, timing register phases and the verdict.
// Depends on acir_pkg, ac_ir_frame_pulse_encoder and acir_frame_checker.
module tb_ac_ir_frame_pulse_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int         RESULT_GOAL  = 1650;
    localparam int         CALM_FROM    = 1400;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_op          = 1'b0;
    logic [7:0]  s_temperature = 8'd0;
    logic [2:0]  s_op_mode     = 3'd0;
    logic [1:0]  s_fan_speed   = 2'd0;
    logic        s_swing_on    = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [15:0] m_duration;
    logic        m_is_mark;
    logic        m_last;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_index     = 3'd0;
    logic [15:0] cfg_wdata     = 16'd0;

    int fail_count;
    int pending;
    int results_seen = 0;
    int sink_hold    = 0;
    bit idle_on      = 1'b0;

    ac_ir_frame_pulse_encoder uut (.*);

    acir_frame_checker checker_i (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 15);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            results_seen <= results_seen + 1;
    end

    task automatic send_word(logic op, logic [7:0] temp, logic [2:0] mode,
                             logic [1:0] fan, logic swing);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_temperature <= temp;
        s_op_mode     <= mode;
        s_fan_speed   <= fan;
        s_swing_on    <= swing;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(logic op);
        send_word(op, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // let every pending result drain, then wait out any ignored words
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_timing(logic [15:0] hm, logic [15:0] hg, logic [15:0] bm,
                                logic [15:0] os, logic [15:0] zs, logic [15:0] tg);
        write_reg(acir_pkg::CFG_HEADER_MARK, hm);
        write_reg(acir_pkg::CFG_HEADER_GAP, hg);
        write_reg(acir_pkg::CFG_BIT_MARK, bm);
        write_reg(acir_pkg::CFG_ONE_SPACE, os);
        write_reg(acir_pkg::CFG_ZERO_SPACE, zs);
        write_reg(acir_pkg::CFG_TRAILER_GAP, tg);
        // out-of-range index must not disturb any register
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  16'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_timing();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int phase;
        int pick;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_on = 1'b1;
        send_word(acir_pkg::OP_NEXT, 8'hFF, 3'd7, 2'd3, 1'b1);
        send_word(acir_pkg::OP_START, 8'd0, 3'd5, 2'd0, 1'b0);
        repeat (4) send_word(acir_pkg::OP_NEXT, 8'h00, 3'd0, 2'd0, 1'b0);
        send_word(acir_pkg::OP_START, 8'd255, 3'd6, 2'd1, 1'b1);
        send_word(acir_pkg::OP_NEXT, 8'hFF, 3'd7, 2'd3, 1'b1);
        send_word(acir_pkg::OP_START, acir_pkg::TEMP_MIN, acir_pkg::MODE_AUTO, 2'd2, 1'b0);
        send_word(acir_pkg::OP_START, acir_pkg::TEMP_MAX, 3'd1, 2'd3, 1'b1);
        send_word(acir_pkg::OP_START, 8'd31, 3'd2, 2'd2, 1'b0);
        send_word(acir_pkg::OP_START, 8'd15, 3'd3, 2'd1, 1'b1);
        send_word(acir_pkg::OP_START, 8'd23, acir_pkg::MODE_FAN, 2'd3, 1'b0);
        send_word(acir_pkg::OP_START, 8'd128, 3'd7, 2'd0, 1'b1);
        repeat (6) send_word(acir_pkg::OP_NEXT, 8'hFF, 3'd7, 2'd3, 1'b1);
        drain();

        phase = 0;
        while (results_seen < RESULT_GOAL) begin
            case (phase)
                0: apply_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_timing(acir_pkg::RST_HEADER_MARK, acir_pkg::RST_HEADER_GAP,
                                acir_pkg::RST_BIT_MARK, acir_pkg::RST_ONE_SPACE,
                                acir_pkg::RST_ZERO_SPACE, acir_pkg::RST_TRAILER_GAP);
                default: apply_timing(pick_timing(), pick_timing(), pick_timing(),
                                      pick_timing(), pick_timing(), pick_timing());
            endcase
            phase++;
            repeat ($urandom_range(1, 3)) begin
                idle_on = (results_seen < CALM_FROM) && ($urandom_range(0, 3) != 0);
                pick    = $urandom_range(0, 9);
                if (pick < 6) begin
                    send_random(acir_pkg::OP_START);
                    repeat (acir_pkg::POS_LAST) send_random(acir_pkg::OP_NEXT);
                    repeat ($urandom_range(0, 2)) send_random(acir_pkg::OP_NEXT);
                end else if (pick < 9) begin
                    send_random(acir_pkg::OP_START);
                    repeat ($urandom_range(0, 80)) send_random(acir_pkg::OP_NEXT);
                end else begin
                    repeat ($urandom_range(1, 6)) send_random(1'($urandom_range(0, 1)));
                end
            end
            drain();
        end

        idle_on = 1'b0;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
